@@ sv/ordered_byte_list_engine_assert.svh @@
// Assertion macros shared by the ordered byte list engine RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ORDERED_BYTE_LIST_ENGINE_ASSERT_SVH
`define ORDERED_BYTE_LIST_ENGINE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define OBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define OBL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/obl_pkg.sv @@
// Package of the ordered byte list engine: sizes, command and status codes,
// cell control types. No dependencies.
`default_nettype none

package obl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 5;
  localparam int LEAVES   = 1 << $clog2(CAPACITY);
  localparam int IN_W     = 24;
  localparam int OUT_W    = 16;

  typedef logic signed [7:0] byte_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam byte_t BYTE_MIN = -8'sd128;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_HELD = 2'd2;
  localparam logic [1:0] ST_APPENDED = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    byte_t    target;     // byte the cells compare against
    byte_t    ins_value;  // byte placed at the insertion point
    logic     mark_free;  // an unused cell counts as insertion point
    logic     mark_all;   // every cell counts, so the front wins
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/obl_cell.sv @@
// One list cell: holds a byte and its used bit, compares against the target
// and shifts toward either neighbor. Depends on obl_pkg.
`default_nettype none

module obl_cell (
  input  logic               clk,
  input  logic               rst,
  input  obl_pkg::cell_ctrl_t ctrl,
  input  obl_pkg::byte_t     left_value,
  input  logic               left_used,
  input  obl_pkg::byte_t     right_value,
  input  logic               right_used,
  input  logic               hit_in,
  output logic               hit_out,
  output logic               eq,
  output obl_pkg::byte_t     value,
  output logic               used
);
  import obl_pkg::*;

  logic  mark;
  logic  first;
  byte_t value_next;
  logic  used_next;

  assign eq      = used && (value == ctrl.target);
  assign mark    = ctrl.mark_all || eq || (ctrl.mark_free && !used);
  assign first   = mark && !hit_in;
  assign hit_out = hit_in || mark;

  always_comb begin
    value_next = value;
    used_next  = used;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (first) begin
          value_next = ctrl.ins_value;
          used_next  = 1'b1;
        end else if (hit_in) begin
          value_next = left_value;
          used_next  = left_used;
        end
      end
      OP_REMOVE: begin
        if (first || hit_in) begin
          value_next = right_value;
          used_next  = right_used;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      used <= 1'b0;
    end else begin
      used <= used_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/obl_max_tree.sv @@
// Signed maximum over the used cells, as a balanced compare tree.
// Depends on obl_pkg.
`default_nettype none

module obl_max_tree (
  input  obl_pkg::byte_t          values [obl_pkg::CAPACITY],
  input  logic [obl_pkg::CAPACITY-1:0] used,
  output obl_pkg::byte_t          largest
);
  import obl_pkg::*;

  byte_t node [2*LEAVES-1];

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < CAPACITY && used[i]) begin
        node[LEAVES-1+i] = values[i];
      end else begin
        node[LEAVES-1+i] = BYTE_MIN;
      end
    end
    for (int k = LEAVES - 2; k >= 0; k--) begin
      node[k] = (node[2*k+1] > node[2*k+2]) ? node[2*k+1] : node[2*k+2];
    end
  end

  assign largest = node[0];

endmodule

`default_nettype wire

@@ sv/ordered_byte_list_engine.sv @@
// Ordered byte list engine, top level: command decode, cell chain, count and
// result register. Depends on obl_pkg, obl_cell, obl_max_tree and the assert header.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one command per transaction. The cell
//   chain is updated at the edge that accepts the command: every cell compares
//   its byte at once, a one-bit chain picks the first match, and each cell
//   takes its own, its left or its right neighbor's byte.
//   At the next edge the signed maximum of the used cells (a compare tree) and
//   the status and count land in the output register, and m_tvalid rises.
//   An item goes through the chain update and then the tree into the result
//   register; s_tready stays low while busy, and the next command is taken
//   as soon as the result slot is free or being taken. While the receiver
//   holds m_tready low the result stays and s_tready is low. Reset clears
//   every used bit, the count and m_tvalid; cell bytes are not cleared,
//   since only used cells are ever read.
`default_nettype none

`include "ordered_byte_list_engine_assert.svh"

module ordered_byte_list_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // cmd[1:0], value[9:2], key[17:10], zero[23:18]
  input  logic [obl_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[1:0], entry_count[6:2], largest_value[14:7], largest_valid[15]
  output logic [obl_pkg::OUT_W-1:0] m_tdata
);
  import obl_pkg::*;

  logic [1:0] in_cmd;
  byte_t      in_value;
  byte_t      in_key;

  logic       accept;
  logic       busy;
  count_t     count;
  count_t     count_next;
  logic [1:0] status_q;
  logic [1:0] status_next;
  logic       full;
  logic       any_eq;

  cell_ctrl_t ctrl;

  byte_t             cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_used;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY:0]   hit;
  byte_t             tree_max;

  logic [1:0]         out_status;
  logic [ENTRY_W-1:0] out_count;
  byte_t              out_largest;
  logic               out_valid_bit;

  assign in_cmd   = s_tdata[1:0];
  assign in_value = s_tdata[9:2];
  assign in_key   = s_tdata[17:10];

  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign any_eq   = |cell_eq;

  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.target    = in_value;
    ctrl.ins_value = in_value;
    ctrl.mark_free = 1'b0;
    ctrl.mark_all  = 1'b0;
    status_next    = ST_DONE;
    count_next     = count;
    unique case (in_cmd)
      CMD_PUSH: begin
        ctrl.mark_all = 1'b1;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.op    = OP_INSERT;
          count_next = count + count_t'(1);
        end
      end
      CMD_REMOVE: begin
        if (any_eq) begin
          ctrl.op    = OP_REMOVE;
          count_next = count - count_t'(1);
        end else begin
          status_next = ST_NOT_HELD;
        end
      end
      CMD_INSERT: begin
        ctrl.target    = in_key;
        ctrl.mark_free = 1'b1;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.op     = OP_INSERT;
          count_next  = count + count_t'(1);
          status_next = any_eq ? ST_DONE : ST_APPENDED;
        end
      end
      default: begin
      end
    endcase
    // hold the chain unless a transaction is accepted this cycle
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    byte_t lv;
    logic  lu;
    byte_t rv;
    logic  ru;
    if (i == 0) begin : g_front
      assign lv = '0;
      assign lu = 1'b0;
    end else begin : g_inner_l
      assign lv = cell_value[i-1];
      assign lu = cell_used[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign rv = '0;
      assign ru = 1'b0;
    end else begin : g_inner_r
      assign rv = cell_value[i+1];
      assign ru = cell_used[i+1];
    end
    obl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_value (lv),
      .left_used  (lu),
      .right_value(rv),
      .right_used (ru),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .eq         (cell_eq[i]),
      .value      (cell_value[i]),
      .used       (cell_used[i])
    );
  end

  obl_max_tree u_max (
    .values (cell_value),
    .used   (cell_used),
    .largest(tree_max)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
    end
    if (busy) begin
      out_status    <= status_q;
      out_count     <= ENTRY_W'(count);
      out_valid_bit <= (count != '0);
      out_largest   <= (count != '0) ? tree_max : '0;
    end
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      busy <= accept;
      if (accept) begin
        count <= count_next;
      end
      if (busy) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {out_valid_bit, out_largest, out_count, out_status};

  `OBL_ASSERT(a_used_matches_count, $countones(cell_used) == int'(count), "used bits disagree with count")
  `OBL_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `OBL_ASSERT_NEXT(a_accept_then_busy, accept, busy && !s_tready, "no busy cycle after accept")
  `OBL_ASSERT_NEXT(a_busy_then_result, busy, m_tvalid && !busy, "result not registered after busy")
  `OBL_ASSERT(a_valid_bit_count, !m_tvalid || (out_valid_bit == (out_count != '0)),
              "largest_valid disagrees with entry_count")

endmodule

`default_nettype wire
